// ===== src/three_axis_fir_lowpass_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the three-axis FIR low-pass block
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef THREE_AXIS_FIR_LOWPASS_DEFINES_SVH
`define THREE_AXIS_FIR_LOWPASS_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define TAFL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define TAFL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/tafl_pkg.sv =====
// ----------------------------------------------------------------------------
// tafl_pkg
// Types, constants and the coefficient table of the three-axis FIR low-pass.
// ----------------------------------------------------------------------------
package tafl_pkg;

   localparam int CHANNELS            = 3;
   localparam int CH_W                = $clog2(CHANNELS);
   localparam int COEF_W              = 12;
   localparam int FRAC_BITS           = 15;
   localparam int HALF_COEFS          = 11;
   localparam int TAPS_DEFAULT        = 21;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   localparam logic [COEF_W-1:0] HALF_COEF [HALF_COEFS] = '{
      12'd604, 12'd705, 12'd891, 12'd1135, 12'd1406, 12'd1676,
      12'd1924, 12'd2135, 12'd2296, 12'd2397, 12'd2431
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN1,
      ST_DRAIN2,
      ST_FINISH,
      ST_COMMIT
   } tafl_state_type;

   typedef struct packed {
      logic load;
      logic mac;
      logic finish;
      logic commit;
   } tafl_cmd_type;

   typedef struct packed {
      logic last_tap;
      logic last_chan;
   } tafl_status_type;

   function automatic logic [COEF_W-1:0] coef_at(input int k, input int taps);
      int m;
      m = taps - 1 - k;
      if (k < m) m = k;
      if (m < 0) m = 0;
      if (m > HALF_COEFS - 1) m = HALF_COEFS - 1;
      return HALF_COEF[m];
   endfunction

endpackage

// ===== src/tafl_controller.sv =====
// ----------------------------------------------------------------------------
// tafl_controller
// Sequencer that walks the taps of each channel and hands off results.
// ----------------------------------------------------------------------------
module tafl_controller
   import tafl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  tafl_status_type status,
   output tafl_cmd_type    cmd
);

   tafl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MAC;
         end
         ST_MAC: begin
            if (status.last_tap) state_in = ST_DRAIN1;
         end
         ST_DRAIN1: state_in = ST_DRAIN2;
         ST_DRAIN2: state_in = ST_FINISH;
         ST_FINISH: begin
            state_in = status.last_chan ? ST_COMMIT : ST_MAC;
         end
         ST_COMMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_MAC:    cmd.mac    = 1'b1;
         ST_FINISH: cmd.finish = 1'b1;
         ST_COMMIT: cmd.commit = out_free;
         default: begin
            cmd       = '0;
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/tafl_datapath.sv =====
// ----------------------------------------------------------------------------
// tafl_datapath
// Delay-line memory, shared multiply-accumulate pipeline, rounding and
// saturation, and the result registers.
// ----------------------------------------------------------------------------
module tafl_datapath
   import tafl_pkg::*;
#(
   parameter int TAPS        = TAPS_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  tafl_cmd_type                  cmd,
   output tafl_status_type               status,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_x,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_y,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_z,
   output logic signed [SAMPLE_BITS-1:0] rsp_filtered_x,
   output logic signed [SAMPLE_BITS-1:0] rsp_filtered_y,
   output logic signed [SAMPLE_BITS-1:0] rsp_filtered_z
);

   localparam int DLY    = TAPS - 1;
   localparam int SLOT_W = (DLY > 1) ? $clog2(DLY) : 1;
   localparam int TAP_W  = $clog2(TAPS);
   localparam int ADDR_W = CH_W + SLOT_W;
   localparam int PROD_W = SAMPLE_BITS + COEF_W + 1;
   localparam int ACC_W  = PROD_W + TAP_W;
   localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (FRAC_BITS - 1);

   logic signed [SAMPLE_BITS-1:0] mem [2**ADDR_W];

   logic signed [SAMPLE_BITS-1:0] x_ff   [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] res_ff [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] out_ff [CHANNELS];

   logic [TAP_W-1:0]  tap_ff, fill_ff;
   logic [CH_W-1:0]   chan_ff;
   logic [SLOT_W-1:0] rp_ff, wp_ff;

   logic                          s1_valid_ff, s1_tap0_ff, s1_zero_ff;
   logic [COEF_W-1:0]             s1_coef_ff;
   logic signed [SAMPLE_BITS-1:0] rd_ff;
   logic                          s2_valid_ff;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0]       acc_ff;

   logic signed [SAMPLE_BITS-1:0] operand;
   logic signed [COEF_W:0]        coef_s;
   logic signed [ACC_W-1:0]       biased, scaled;
   logic [ACC_W-SAMPLE_BITS:0]    upper;
   logic signed [SAMPLE_BITS-1:0] sat;
   logic [ADDR_W-1:0]             raddr, waddr;

   function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
      return (s == '0) ? SLOT_W'(DLY - 1) : SLOT_W'(s - 1'b1);
   endfunction

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(DLY - 1)) ? '0 : SLOT_W'(s + 1'b1);
   endfunction

   assign status.last_tap  = (tap_ff == TAP_W'(TAPS - 1));
   assign status.last_chan = (chan_ff == CH_W'(CHANNELS - 1));

   assign raddr = {chan_ff, rp_ff};
   assign waddr = {chan_ff, wp_ff};

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         mem[waddr] <= x_ff[chan_ff];
      end
      rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff      <= '0;
         chan_ff     <= '0;
         wp_ff       <= '0;
         rp_ff       <= '0;
         fill_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.mac;
         s2_valid_ff <= s1_valid_ff;
         if (cmd.mac) begin
            tap_ff <= TAP_W'(tap_ff + 1'b1);
            rp_ff  <= (tap_ff == '0) ? slot_dec(wp_ff) : slot_dec(rp_ff);
         end
         if (cmd.finish) begin
            tap_ff  <= '0;
            chan_ff <= status.last_chan ? '0 : CH_W'(chan_ff + 1'b1);
         end
         if (cmd.commit) begin
            wp_ff <= slot_inc(wp_ff);
            if (fill_ff != TAP_W'(TAPS - 1)) begin
               fill_ff <= TAP_W'(fill_ff + 1'b1);
            end
         end
      end
   end

   always_comb begin
      if (s1_tap0_ff) begin
         operand = x_ff[chan_ff];
      end else if (s1_zero_ff) begin
         operand = '0;
      end else begin
         operand = rd_ff;
      end
      coef_s  = $signed({1'b0, s1_coef_ff});
      prod_in = PROD_W'(operand) * PROD_W'(coef_s);
   end

   always_comb begin
      biased = acc_ff + ROUND_BIAS;
      scaled = biased >>> FRAC_BITS;
      upper  = scaled[ACC_W-1:SAMPLE_BITS-1];
      if ((&upper) || !(|upper)) begin
         sat = scaled[SAMPLE_BITS-1:0];
      end else if (scaled[ACC_W-1]) begin
         sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff[0] <= req_sample_x;
         x_ff[1] <= req_sample_y;
         x_ff[2] <= req_sample_z;
      end
      s1_tap0_ff <= (tap_ff == '0);
      s1_zero_ff <= (tap_ff > fill_ff);
      s1_coef_ff <= coef_at(int'(tap_ff), TAPS);
      prod_ff    <= prod_in;
      if (cmd.mac && tap_ff == '0) begin
         acc_ff <= '0;
      end else if (s2_valid_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (cmd.finish) begin
         res_ff[chan_ff] <= sat;
      end
      if (cmd.commit) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_filtered_x = out_ff[0];
   assign rsp_filtered_y = out_ff[1];
   assign rsp_filtered_z = out_ff[2];

endmodule

// ===== src/three_axis_fir_lowpass.sv =====
// ----------------------------------------------------------------------------
// three_axis_fir_lowpass
// Top level: three independent 21-tap symmetric low-pass FIR filters over
// one x/y/z sample triple per item, sharing one multiply-accumulate unit.
// ----------------------------------------------------------------------------
// An item is accepted in the idle state. The single shared multiplier then
// does one tap of one axis per cycle and walks the axes in turn; after each
// axis, the drain states DRAIN1 and DRAIN2 empty the multiply pipeline, a
// finish state stores the rounded, saturated result, and a commit state then
// hands the triple to the output register. The next item can be accepted
// once that result is valid, so an item is not taken before the last one is
// through. A finished result waits in its output register while the next
// item is accepted; the next result is held back only if that register is
// still full when it is ready. Delay lines are read as zero after reset, as
// a fill count zeroes taps not yet written; no clearing pass is needed.
module three_axis_fir_lowpass
   import tafl_pkg::*;
#(
   parameter int TAPS        = TAPS_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_x,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_y,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_filtered_x,
   output logic signed [SAMPLE_BITS-1:0] rsp_filtered_y,
   output logic signed [SAMPLE_BITS-1:0] rsp_filtered_z
);

   tafl_cmd_type    cmd;
   tafl_status_type status;

   tafl_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tafl_datapath #(
      .TAPS        (TAPS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sample_x   (req_sample_x),
      .req_sample_y   (req_sample_y),
      .req_sample_z   (req_sample_z),
      .rsp_filtered_x (rsp_filtered_x),
      .rsp_filtered_y (rsp_filtered_y),
      .rsp_filtered_z (rsp_filtered_z)
   );

endmodule

// ===== src/tafl_checker.sv =====
// ----------------------------------------------------------------------------
// tafl_checker
// Port-level checks of the three-axis FIR low-pass, bound to the top level.
// ----------------------------------------------------------------------------
`include "three_axis_fir_lowpass_defines.svh"

module tafl_checker #(
   parameter int SAMPLE_BITS = 16
)
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [SAMPLE_BITS-1:0] rsp_filtered_x,
   input logic [SAMPLE_BITS-1:0] rsp_filtered_y,
   input logic [SAMPLE_BITS-1:0] rsp_filtered_z
);

   `TAFL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_filtered_x) && $stable(rsp_filtered_y) && $stable(rsp_filtered_z), "stalled result changed")
   `TAFL_ASSERT_NOW(a_reset_quiet, clock, 1'b0, $past(reset) && !reset, !rsp_valid, "result valid after reset")
   `TAFL_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall && !$rose(rsp_valid), "not busy after an accepted item")
   `TAFL_ASSERT_NOW(a_idle_on_result, clock, reset, $rose(rsp_valid), !req_stall, "result appeared while still busy")

endmodule

bind three_axis_fir_lowpass tafl_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tafl_checker (.*);
